### src/sfgr_pkg.sv
// Package for the scaled glyph rasteriser: widths, state type, character decode
// and the 5x7 font table.
// No dependencies.
package sfgr_pkg;

    localparam int GLYPH_COUNT  = 40;
    localparam int GLYPH_WIDTH  = 5;
    localparam int GLYPH_HEIGHT = 7;
    localparam int GLYPH_BITS   = GLYPH_WIDTH * GLYPH_HEIGHT;

    localparam int CODE_W  = 8;
    localparam int X_W     = 10;
    localparam int Y_W     = 9;
    localparam int SCALE_W = 4;
    localparam int SQX_W   = 11;
    localparam int SQY_W   = 10;
    localparam int IDX_W   = 8;

    localparam logic [IDX_W-1:0] IDX_SPACE  = 8'd36;
    localparam logic [IDX_W-1:0] IDX_PERIOD = 8'd37;
    localparam logic [IDX_W-1:0] IDX_COLON  = 8'd38;
    localparam logic [IDX_W-1:0] IDX_HYPHEN = 8'd39;
    localparam logic [X_W-1:0]   CURSOR_MAX = 10'd1023;

    typedef logic [GLYPH_BITS-1:0] t_glyph;
    typedef logic [IDX_W-1:0]      t_glyph_idx;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } t_state;

    typedef struct packed {
        logic       known;
        t_glyph_idx idx;
    } t_decode;

    // Lower case letters share the upper case glyphs.
    function automatic t_decode decode_char(input logic [CODE_W-1:0] code);
        t_decode d;
        d.known = 1'b1;
        d.idx   = '0;
        if (code inside {[8'h30:8'h39]}) begin
            d.idx = code - 8'h30;
        end else if (code inside {[8'h41:8'h5A]}) begin
            d.idx = code - 8'h41 + 8'd10;
        end else if (code inside {[8'h61:8'h7A]}) begin
            d.idx = code - 8'h61 + 8'd10;
        end else if (code == 8'h20) begin
            d.idx = IDX_SPACE;
        end else if (code == 8'h2E) begin
            d.idx = IDX_PERIOD;
        end else if (code == 8'h3A) begin
            d.idx = IDX_COLON;
        end else if (code == 8'h2D) begin
            d.idx = IDX_HYPHEN;
        end else begin
            d.known = 1'b0;
        end
        return d;
    endfunction

    // Column-major: bits [6:0] are column 0, bit 0 of each column is the top row.
    function automatic t_glyph font_glyph(input t_glyph_idx idx);
        logic [7:0] c [GLYPH_WIDTH];
        t_glyph g;
        case (idx)
            8'd0:  c = '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};
            8'd1:  c = '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
            8'd2:  c = '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
            8'd3:  c = '{8'h21, 8'h41, 8'h45, 8'h4B, 8'h31};
            8'd4:  c = '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
            8'd5:  c = '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
            8'd6:  c = '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30};
            8'd7:  c = '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
            8'd8:  c = '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
            8'd9:  c = '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E};
            8'd10: c = '{8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
            8'd11: c = '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36};
            8'd12: c = '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22};
            8'd13: c = '{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C};
            8'd14: c = '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41};
            8'd15: c = '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01};
            8'd16: c = '{8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A};
            8'd17: c = '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
            8'd18: c = '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
            8'd19: c = '{8'h20, 8'h40, 8'h41, 8'h3F, 8'h01};
            8'd20: c = '{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41};
            8'd21: c = '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40};
            8'd22: c = '{8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
            8'd23: c = '{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F};
            8'd24: c = '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
            8'd25: c = '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06};
            8'd26: c = '{8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E};
            8'd27: c = '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46};
            8'd28: c = '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31};
            8'd29: c = '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
            8'd30: c = '{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
            8'd31: c = '{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
            8'd32: c = '{8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F};
            8'd33: c = '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
            8'd34: c = '{8'h07, 8'h08, 8'h70, 8'h08, 8'h07};
            8'd35: c = '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43};
            8'd37: c = '{8'h00, 8'h00, 8'h60, 8'h60, 8'h00};
            8'd38: c = '{8'h00, 8'h36, 8'h36, 8'h00, 8'h00};
            8'd39: c = '{8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
            default: c = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        endcase
        for (int k = 0; k < GLYPH_WIDTH; k++) begin
            g[k*GLYPH_HEIGHT +: GLYPH_HEIGHT] = c[k][GLYPH_HEIGHT-1:0];
        end
        return g;
    endfunction

endpackage

### src/sfgr_if.sv
// Channel interfaces for the glyph rasteriser: character input and square output.
// Depends on sfgr_pkg for field widths.
interface sfgr_in_if;
    logic                              valid;
    logic                              ready;
    logic [sfgr_pkg::CODE_W-1:0]       char_code;
    logic [sfgr_pkg::X_W-1:0]          start_x;
    logic [sfgr_pkg::Y_W-1:0]          row_y;
    logic [sfgr_pkg::SCALE_W-1:0]      pixel_scale;
    logic                              first_char;

    modport source (output valid, char_code, start_x, row_y, pixel_scale, first_char,
                    input ready);
    modport sink   (input valid, char_code, start_x, row_y, pixel_scale, first_char,
                    output ready);
endinterface

interface sfgr_out_if;
    logic                              valid;
    logic                              ready;
    logic [sfgr_pkg::SQX_W-1:0]        square_x;
    logic [sfgr_pkg::SQY_W-1:0]        square_y;
    logic [sfgr_pkg::SCALE_W-1:0]      square_size;
    logic                              last_square;

    modport source (output valid, square_x, square_y, square_size, last_square,
                    input ready);
    modport sink   (input valid, square_x, square_y, square_size, last_square,
                    output ready);
endinterface

### src/scaled_font_glyph_rasterizer.sv
// The ROM read register is loaded when a character is taken, and every square then
// passes through the output register. No new character is taken until the scan is
// done; the scan steps one font pixel a cycle from the ROM read register and stops
// after the last set pixel. Output stalls hold the scan. Synchronous active-low reset
// clears the cursor to column 0 and empties the output register.
module scaled_font_glyph_rasterizer #(
    parameter int GLYPH_COUNT = sfgr_pkg::GLYPH_COUNT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sfgr_in_if.sink     i_in,
    sfgr_out_if.source  o_out
);

    localparam int ROW_W  = 3;
    localparam int XOFF_W = 6;
    localparam int YOFF_W = 7;
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(sfgr_pkg::GLYPH_HEIGHT - 1);

    sfgr_pkg::t_state r_state, n_state;

    logic [sfgr_pkg::X_W-1:0]     r_cursor, n_cursor;
    logic [sfgr_pkg::X_W-1:0]     r_base;
    logic [sfgr_pkg::Y_W-1:0]     r_row_y;
    logic [sfgr_pkg::SCALE_W-1:0] r_scale;
    logic [ROW_W-1:0]             r_row;
    logic [XOFF_W-1:0]            r_xoff;
    logic [YOFF_W-1:0]            r_yoff;

    logic                          r_out_valid;
    logic [sfgr_pkg::SQX_W-1:0]    r_sq_x;
    logic [sfgr_pkg::SQY_W-1:0]    r_sq_y;
    logic [sfgr_pkg::SCALE_W-1:0]  r_sq_size;
    logic                          r_sq_last;

    sfgr_pkg::t_glyph glyph;
    logic             accept;
    logic             out_free;
    logic             step;
    logic             emit;
    logic             is_last;
    logic             in_ready;
    logic [sfgr_pkg::X_W-1:0] base_col;
    logic [sfgr_pkg::X_W:0]   cursor_sum;
    logic [YOFF_W-1:0]        advance;

    sfgr_glyph_rom #(
        .GLYPH_COUNT (GLYPH_COUNT)
    ) u_rom (
        .i_clk       (i_clk),
        .i_load      (accept),
        .i_char_code (i_in.char_code),
        .i_shift     (step),
        .o_glyph     (glyph)
    );

    assign accept   = i_in.valid && in_ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign is_last  = (glyph[sfgr_pkg::GLYPH_BITS-1:1] == '0);

    // Cursor update: six glyph pixels per character, clamped at the right edge.
    assign base_col   = i_in.first_char ? i_in.start_x : r_cursor;
    assign advance    = YOFF_W'({i_in.pixel_scale, 2'b00}) + YOFF_W'({i_in.pixel_scale, 1'b0});
    assign cursor_sum = {1'b0, base_col} + (sfgr_pkg::X_W+1)'(advance);
    assign n_cursor   = (cursor_sum > {1'b0, sfgr_pkg::CURSOR_MAX})
                        ? sfgr_pkg::CURSOR_MAX : cursor_sum[sfgr_pkg::X_W-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            sfgr_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = sfgr_pkg::ST_SCAN;
                end
            end
            sfgr_pkg::ST_SCAN: begin
                if ((glyph == '0) || (emit && is_last)) begin
                    n_state = sfgr_pkg::ST_IDLE;
                end
            end
            default: n_state = sfgr_pkg::ST_IDLE;
        endcase
    end

    // A clear pixel always advances; a set one waits for room in the output register.
    always_comb begin
        in_ready = 1'b0;
        step     = 1'b0;
        emit     = 1'b0;
        case (r_state)
            sfgr_pkg::ST_IDLE: begin
                in_ready = 1'b1;
            end
            sfgr_pkg::ST_SCAN: begin
                step = (glyph != '0) && (!glyph[0] || out_free);
                emit = step && glyph[0];
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sfgr_pkg::ST_IDLE;
            r_cursor    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_cursor <= n_cursor;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_base  <= base_col;
            r_row_y <= i_in.row_y;
            r_scale <= i_in.pixel_scale;
            r_row   <= '0;
            r_xoff  <= '0;
            r_yoff  <= '0;
        end else if (step) begin
            if (r_row == LAST_ROW) begin
                r_row  <= '0;
                r_yoff <= '0;
                r_xoff <= r_xoff + XOFF_W'(r_scale);
            end else begin
                r_row  <= r_row + 1'b1;
                r_yoff <= r_yoff + YOFF_W'(r_scale);
            end
        end
        if (emit) begin
            r_sq_x    <= {1'b0, r_base} + sfgr_pkg::SQX_W'(r_xoff);
            r_sq_y    <= {1'b0, r_row_y} + sfgr_pkg::SQY_W'(r_yoff);
            r_sq_size <= r_scale;
            r_sq_last <= is_last;
        end
    end

    assign i_in.ready        = in_ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.square_x    = r_sq_x;
    assign o_out.square_y    = r_sq_y;
    assign o_out.square_size = r_sq_size;
    assign o_out.last_square = r_sq_last;

endmodule

### src/sfgr_glyph_rom.sv
// Font ROM with a registered read port; the read register doubles as the
// pixel shift register that the scan walks through.
// Depends on sfgr_pkg for the decode and font table.
module sfgr_glyph_rom #(
    parameter int GLYPH_COUNT = sfgr_pkg::GLYPH_COUNT
) (
    input  logic                        i_clk,
    input  logic                        i_load,
    input  logic [sfgr_pkg::CODE_W-1:0] i_char_code,
    input  logic                        i_shift,
    output sfgr_pkg::t_glyph            o_glyph
);

    sfgr_pkg::t_decode dec;
    logic              glyph_ok;
    sfgr_pkg::t_glyph  r_glyph;

    assign dec      = sfgr_pkg::decode_char(i_char_code);
    assign glyph_ok = dec.known && (int'(dec.idx) < GLYPH_COUNT);

    // Unknown characters read as an empty glyph, so nothing is drawn.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_glyph <= glyph_ok ? sfgr_pkg::font_glyph(dec.idx) : '0;
        end else if (i_shift) begin
            r_glyph <= r_glyph >> 1;
        end
    end

    assign o_glyph = r_glyph;

endmodule

### src/sfgr_checker.sv
// Port-level checks for the glyph rasteriser, bound to the top level.
// Depends on sfgr_pkg for field widths.
module sfgr_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic [sfgr_pkg::SCALE_W-1:0]  i_in_scale,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [sfgr_pkg::SQX_W-1:0]    i_out_x,
    input logic [sfgr_pkg::SQY_W-1:0]    i_out_y,
    input logic [sfgr_pkg::SCALE_W-1:0]  i_out_size,
    input logic                          i_out_last
);

    logic [sfgr_pkg::SCALE_W-1:0] r_scale;

    always_ff @(posedge i_clk) begin
        if (i_in_valid && i_in_ready) begin
            r_scale <= i_in_scale;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_x)
            && $stable(i_out_y) && $stable(i_out_size) && $stable(i_out_last))
        else $error("stalled square changed");

    // Until the final square of a character is shown, no new character is taken.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("character accepted while a glyph is still being drawn");

    // The final square may still wait while the next character is taken, so only the
    // squares before it are held against the latest scale.
    a_size_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> i_out_size == r_scale)
        else $error("square size differs from the character's scale");

endmodule

bind scaled_font_glyph_rasterizer sfgr_checker u_sfgr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_scale  (i_in.pixel_scale),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_x     (o_out.square_x),
    .i_out_y     (o_out.square_y),
    .i_out_size  (o_out.square_size),
    .i_out_last  (o_out.last_square)
);

### sim/testbench.sv
// Testbench for scaled_font_glyph_rasterizer: drives text characters and checks every square
// against a predictor that holds its own copy of the 5x7 font and the text cursor.
// Depends on sfgr_pkg, the sfgr_in_if and sfgr_out_if channel interfaces and the block itself.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_MAX    = 14;
    localparam int DRAIN_TICKS = 40;
    localparam int MAX_SQUARES = sfgr_pkg::GLYPH_WIDTH * sfgr_pkg::GLYPH_HEIGHT;

    typedef struct packed {
        logic [sfgr_pkg::SQX_W-1:0]   x;
        logic [sfgr_pkg::SQY_W-1:0]   y;
        logic [sfgr_pkg::SCALE_W-1:0] size;
        logic                         last;
    } t_square;

    logic i_clk;
    logic i_rst_n;

    sfgr_in_if  char_ch ();
    sfgr_out_if square_ch ();

    scaled_font_glyph_rasterizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (char_ch),
        .o_out   (square_ch)
    );

    t_square                  expected_squares [$];
    logic [sfgr_pkg::X_W-1:0] text_cursor;
    int                       mismatch_count;
    int                       tx_max_gap;
    int                       rx_max_stall;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

    // Column 0 sits in the top byte; bit 0 of each byte is the top row of that column.
    function automatic logic [39:0] font_columns(input int idx);
        case (idx)
            0:  return 40'h3E5149453E;
            1:  return 40'h00427F4000;
            2:  return 40'h4261514946;
            3:  return 40'h2141454B31;
            4:  return 40'h1814127F10;
            5:  return 40'h2745454539;
            6:  return 40'h3C4A494930;
            7:  return 40'h0171090503;
            8:  return 40'h3649494936;
            9:  return 40'h064949291E;
            10: return 40'h7E1111117E;
            11: return 40'h7F49494936;
            12: return 40'h3E41414122;
            13: return 40'h7F4141221C;
            14: return 40'h7F49494941;
            15: return 40'h7F09090901;
            16: return 40'h3E4149497A;
            17: return 40'h7F0808087F;
            18: return 40'h00417F4100;
            19: return 40'h2040413F01;
            20: return 40'h7F08142241;
            21: return 40'h7F40404040;
            22: return 40'h7F020C027F;
            23: return 40'h7F0408107F;
            24: return 40'h3E4141413E;
            25: return 40'h7F09090906;
            26: return 40'h3E4151215E;
            27: return 40'h7F09192946;
            28: return 40'h4649494931;
            29: return 40'h01017F0101;
            30: return 40'h3F4040403F;
            31: return 40'h1F2040201F;
            32: return 40'h3F4038403F;
            33: return 40'h6314081463;
            34: return 40'h0708700807;
            35: return 40'h6151494543;
            37: return 40'h0000606000;
            38: return 40'h0036360000;
            39: return 40'h0808080808;
            default: return 40'h0;
        endcase
    endfunction

    // Returns 1 and the font index when the character has a glyph.
    function automatic bit char_to_glyph(input logic [sfgr_pkg::CODE_W-1:0] code,
                                         output int idx);
        idx = 0;
        if (code >= "0" && code <= "9") idx = code - "0";
        else if (code >= "A" && code <= "Z") idx = code - "A" + 10;
        else if (code >= "a" && code <= "z") idx = code - "a" + 10;
        else if (code == " ") idx = sfgr_pkg::IDX_SPACE;
        else if (code == ".") idx = sfgr_pkg::IDX_PERIOD;
        else if (code == ":") idx = sfgr_pkg::IDX_COLON;
        else if (code == "-") idx = sfgr_pkg::IDX_HYPHEN;
        else return 1'b0;
        return 1'b1;
    endfunction

    // Works out the squares of one character and moves the cursor on.
    function automatic void raster_glyph(input logic [sfgr_pkg::CODE_W-1:0] code,
                                         input logic [sfgr_pkg::X_W-1:0] sx,
                                         input logic [sfgr_pkg::Y_W-1:0] ry,
                                         input logic [sfgr_pkg::SCALE_W-1:0] sc,
                                         input logic first);
        t_square     found [MAX_SQUARES];
        int          n;
        int          idx;
        int          base;
        int          next_col;
        logic [39:0] cols;
        logic [7:0]  line;
        n = 0;
        if (first) text_cursor = sx;
        base = text_cursor;
        if (char_to_glyph(code, idx)) begin
            cols = font_columns(idx);
            for (int col = 0; col < sfgr_pkg::GLYPH_WIDTH; col++) begin
                line = cols[39 - 8*col -: 8];
                for (int row = 0; row < sfgr_pkg::GLYPH_HEIGHT; row++) begin
                    if (line[row]) begin
                        found[n].x    = sfgr_pkg::SQX_W'(base + col * int'(sc));
                        found[n].y    = sfgr_pkg::SQY_W'(int'(ry) + row * int'(sc));
                        found[n].size = sc;
                        found[n].last = 1'b0;
                        n++;
                    end
                end
            end
        end
        if (n > 0) found[n-1].last = 1'b1;
        for (int k = 0; k < n; k++) expected_squares.push_back(found[k]);
        next_col = base + 6 * int'(sc);
        text_cursor = (next_col > int'(sfgr_pkg::CURSOR_MAX))
                      ? sfgr_pkg::CURSOR_MAX : sfgr_pkg::X_W'(next_col);
    endfunction

    // Called at a falling edge with valid low; returns at a falling edge with valid low.
    task automatic send_char(input logic [sfgr_pkg::CODE_W-1:0] code,
                             input logic [sfgr_pkg::X_W-1:0] sx,
                             input logic [sfgr_pkg::Y_W-1:0] ry,
                             input logic [sfgr_pkg::SCALE_W-1:0] sc,
                             input logic first);
        int gap;
        gap = $urandom_range(0, tx_max_gap);
        repeat (gap) @(negedge i_clk);
        char_ch.char_code   = code;
        char_ch.start_x     = sx;
        char_ch.row_y       = ry;
        char_ch.pixel_scale = sc;
        char_ch.first_char  = first;
        char_ch.valid       = 1'b1;
        @(posedge i_clk);
        while (!char_ch.ready) @(posedge i_clk);
        raster_glyph(code, sx, ry, sc, first);
        @(negedge i_clk);
        char_ch.valid = 1'b0;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_squares
        t_square want;
        if (i_rst_n && square_ch.valid && square_ch.ready) begin
            if (expected_squares.size() == 0) begin
                $error("square_x: expected none, got %0d (unexpected square)", square_ch.square_x);
                mismatch_count++;
            end else begin
                want = expected_squares.pop_front();
                check_field("square_x", want.x, square_ch.square_x);
                check_field("square_y", want.y, square_ch.square_y);
                check_field("square_size", want.size, square_ch.square_size);
                check_field("last_square", want.last, square_ch.last_square);
            end
        end
    end

    initial begin : square_sink
        int stall;
        square_ch.ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = $urandom_range(0, rx_max_stall);
            if (stall > 0) begin
                square_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            square_ch.ready = 1'b1;
            @(posedge i_clk);
            while (!square_ch.valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // The cursor must start at column 0 when the first character carries no start flag.
    task automatic test_cursor_after_reset();
        send_char("A", 10'd700, 9'd0, 4'd1, 1'b0);
        send_char("0", 10'd0, 9'd1, 4'd1, 1'b0);
    endtask

    task automatic test_field_extremes();
        send_char("8", 10'd1023, 9'd511, 4'd15, 1'b1);
        // The cursor is now clamped, so this one draws from column 1023 again.
        send_char("M", 10'd0, 9'd511, 4'd15, 1'b0);
        send_char("W", 10'd1000, 9'd0, 4'd15, 1'b1);
        send_char("8", 10'd0, 9'd0, 4'd1, 1'b1);
    endtask

    task automatic test_glyph_classes();
        send_char("Z", 10'd10, 9'd20, 4'd2, 1'b1);
        send_char("a", 10'd0, 9'd20, 4'd2, 1'b0);
        send_char("z", 10'd0, 9'd20, 4'd2, 1'b0);
        send_char("9", 10'd0, 9'd20, 4'd3, 1'b0);
        send_char(" ", 10'd0, 9'd20, 4'd3, 1'b0);
        send_char(".", 10'd0, 9'd20, 4'd3, 1'b0);
        send_char(":", 10'd0, 9'd20, 4'd3, 1'b0);
        send_char("-", 10'd0, 9'd20, 4'd3, 1'b0);
    endtask

    task automatic test_unknown_codes();
        send_char(8'h00, 10'd100, 9'd50, 4'd4, 1'b1);
        send_char(8'hFF, 10'd0, 9'd50, 4'd4, 1'b0);
        send_char(8'h80, 10'd0, 9'd50, 4'd4, 1'b0);
        send_char("/", 10'd0, 9'd50, 4'd4, 1'b0);
        send_char("@", 10'd0, 9'd50, 4'd4, 1'b0);
        send_char("[", 10'd0, 9'd50, 4'd4, 1'b0);
        send_char("{", 10'd0, 9'd50, 4'd4, 1'b0);
        send_char("H", 10'd0, 9'd50, 4'd4, 1'b0);
    endtask

    // A zero scale piles every square on the cursor and leaves the cursor where it is.
    task automatic test_zero_scale();
        send_char("8", 10'd500, 9'd300, 4'd0, 1'b1);
        send_char("W", 10'd0, 9'd300, 4'd1, 1'b0);
    endtask

    task automatic test_random_text(input int n_items, input int tx_gap, input int rx_stall);
        int                           sent;
        int                           len;
        int                           pick;
        logic [sfgr_pkg::CODE_W-1:0]  code;
        logic [sfgr_pkg::X_W-1:0]     sx;
        logic [sfgr_pkg::Y_W-1:0]     ry;
        logic [sfgr_pkg::SCALE_W-1:0] sc;
        logic [sfgr_pkg::SCALE_W-1:0] char_sc;
        logic                         first;
        tx_max_gap   = tx_gap;
        rx_max_stall = rx_stall;
        sent = 0;
        while (sent < n_items) begin
            len  = $urandom_range(1, 12);
            pick = $urandom_range(0, 9);
            sx   = (pick == 0) ? 10'd0 : (pick == 1) ? 10'd1023 :
                   (pick == 2) ? sfgr_pkg::X_W'($urandom_range(900, 1023))
                               : sfgr_pkg::X_W'($urandom);
            ry   = sfgr_pkg::Y_W'($urandom);
            pick = $urandom_range(0, 19);
            sc   = (pick == 0) ? 4'd0 : (pick < 3) ? 4'd15
                                      : sfgr_pkg::SCALE_W'($urandom_range(1, 15));
            // Now and then a string carries on from the cursor of the one before.
            first = ($urandom_range(0, 9) != 0);
            for (int k = 0; k < len && sent < n_items; k++) begin
                pick = $urandom_range(0, 39);
                if ($urandom_range(0, 4) == 0) code = sfgr_pkg::CODE_W'($urandom);
                else if (pick < 10) code = sfgr_pkg::CODE_W'("0" + pick);
                else if (pick < 36)
                    code = sfgr_pkg::CODE_W'(($urandom_range(0, 1) ? "a" : "A") + pick - 10);
                else if (pick == 36) code = " ";
                else if (pick == 37) code = ".";
                else if (pick == 38) code = ":";
                else code = "-";
                char_sc = ($urandom_range(0, 9) == 0) ? sfgr_pkg::SCALE_W'($urandom) : sc;
                send_char(code, (k == 0) ? sx : sfgr_pkg::X_W'($urandom), ry, char_sc,
                          (k == 0) & first);
                sent++;
            end
        end
    endtask

    initial begin
        mismatch_count      = 0;
        text_cursor         = '0;
        tx_max_gap          = IDLE_MAX;
        rx_max_stall        = IDLE_MAX;
        i_rst_n             = 1'b0;
        char_ch.valid       = 1'b0;
        char_ch.char_code   = '0;
        char_ch.start_x     = '0;
        char_ch.row_y       = '0;
        char_ch.pixel_scale = '0;
        char_ch.first_char  = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_cursor_after_reset();
        test_field_extremes();
        test_glyph_classes();
        test_unknown_codes();
        test_zero_scale();
        test_random_text(150, IDLE_MAX, IDLE_MAX);
        test_random_text(100, 0, 0);
        test_random_text(110, IDLE_MAX, 0);
        test_random_text(100, 0, IDLE_MAX);

        while (expected_squares.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TICKS) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
